// ===== sv/qau_pkg.sv =====
`timescale 1ns / 1ps

package qau_pkg;

	// operation codes
	localparam logic [1:0] OP_MUL  = 2'd0;
	localparam logic [1:0] OP_NORM = 2'd1;
	localparam logic [1:0] OP_AVG  = 2'd2;
	localparam logic [1:0] OP_NEG  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	typedef logic [1:0] op_t;
	typedef logic [1:0] status_t;

endpackage

// ===== sv/qau_isqrt_pipe.sv =====
`timescale 1ns / 1ps

// Pipelined integer square root, one result bit per stage, floor result.
module qau_isqrt_pipe #(
	parameter int RW = 33,
	parameter int SW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [2*RW-1:0]   radicand,
	input  logic [SW-1:0]     in_side,
	output logic              out_valid,
	output logic [RW-1:0]     root,
	output logic [SW-1:0]     out_side
);

	logic              v_s    [RW];
	logic [RW:0]       rem_s  [RW];
	logic [RW-1:0]     root_s [RW];
	logic [2*RW-1:0]   rad_s  [RW];
	logic [SW-1:0]     side_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic            v_prev;
		logic [RW:0]     rem_prev;
		logic [RW-1:0]   root_prev;
		logic [2*RW-1:0] rad_prev;
		logic [SW-1:0]   side_prev;
		logic [RW+2:0]   rem_sh;
		logic [RW+2:0]   trial;
		logic [RW+2:0]   diff;
		logic            ge;

		if (k == 0) begin : g_first
			assign v_prev    = in_valid;
			assign rem_prev  = '0;
			assign root_prev = '0;
			assign rad_prev  = radicand;
			assign side_prev = in_side;
		end else begin : g_next
			assign v_prev    = v_s[k-1];
			assign rem_prev  = rem_s[k-1];
			assign root_prev = root_s[k-1];
			assign rad_prev  = rad_s[k-1];
			assign side_prev = side_s[k-1];
		end

		// bring down the next bit pair, try root*4+1
		always_comb begin
			rem_sh = {rem_prev, rad_prev[2*RW-1 -: 2]};
			trial  = {1'b0, root_prev, 2'b01};
			diff   = rem_sh - trial;
			ge     = (rem_sh >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[RW:0] : rem_sh[RW:0];
				root_s[k] <= {root_prev[RW-2:0], ge};
				rad_s[k]  <= {rad_prev[2*RW-3:0], 2'b00};
				side_s[k] <= side_prev;
			end
		end
	end

	assign out_valid = v_s[RW-1];
	assign root      = root_s[RW-1];
	assign out_side  = side_s[RW-1];

endmodule

// ===== sv/qau_div_pipe.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider, four lanes sharing one divisor, one quotient bit per stage.
// The top DW bits of each numerator must be below the divisor.
module qau_div_pipe #(
	parameter int DW = 33,
	parameter int QW = 29,
	parameter int SW = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [DW-1:0]             divisor,
	input  logic [3:0][DW+QW-1:0]     numer,
	input  logic [SW-1:0]             in_side,
	output logic                      out_valid,
	output logic [3:0][QW-1:0]        quot,
	output logic [SW-1:0]             out_side
);

	logic                 v_s    [QW];
	logic [DW-1:0]        d_s    [QW];
	logic [3:0][DW-1:0]   rem_s  [QW];
	logic [3:0][QW-1:0]   nq_s   [QW];
	logic [SW-1:0]        side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic               v_prev;
		logic [DW-1:0]      d_prev;
		logic [3:0][DW-1:0] rem_prev;
		logic [3:0][QW-1:0] nq_prev;
		logic [SW-1:0]      side_prev;
		logic [3:0][DW-1:0] rem_nx;
		logic [3:0][QW-1:0] nq_nx;
		logic [DW:0]        rem_sh [4];
		logic [DW:0]        dext;
		logic               ge     [4];

		if (k == 0) begin : g_first
			assign v_prev    = in_valid;
			assign d_prev    = divisor;
			assign side_prev = in_side;
			for (genvar l = 0; l < 4; l++) begin : g_lane
				assign rem_prev[l] = numer[l][DW+QW-1 -: DW];
				assign nq_prev[l]  = numer[l][QW-1:0];
			end
		end else begin : g_next
			assign v_prev    = v_s[k-1];
			assign d_prev    = d_s[k-1];
			assign rem_prev  = rem_s[k-1];
			assign nq_prev   = nq_s[k-1];
			assign side_prev = side_s[k-1];
		end

		// shift in the next numerator bit, subtract when it fits
		always_comb begin
			dext = {1'b0, d_prev};
			for (int l = 0; l < 4; l++) begin
				rem_sh[l] = {rem_prev[l], nq_prev[l][QW-1]};
				ge[l]     = (rem_sh[l] >= dext);
				rem_nx[l] = ge[l] ? DW'(rem_sh[l] - dext) : rem_sh[l][DW-1:0];
				nq_nx[l]  = {nq_prev[l][QW-2:0], ge[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k]    <= d_prev;
				rem_s[k]  <= rem_nx;
				nq_s[k]   <= nq_nx;
				side_s[k] <= side_prev;
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign quot      = nq_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule

// ===== sv/quaternion_arith_unit_core.sv =====
`timescale 1ns / 1ps
// Fixed-point quaternion unit: multiply, normalize, average, negate.
// Every operation passes through the same pipeline registers:
// three product/sum stages, one square-root stage per root bit (W+1), one numerator stage,
// one divide stage per quotient bit (F+1) and the output register.
// Throughput: one item per cycle; the whole pipe holds when the output item is not taken.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
module quaternion_arith_unit_core #(
	parameter int COMPONENT_WIDTH = 32,
	parameter int FRACTION_BITS   = 28
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  qau_pkg::op_t                      operation,
	input  logic signed [COMPONENT_WIDTH-1:0] a_x,
	input  logic signed [COMPONENT_WIDTH-1:0] a_y,
	input  logic signed [COMPONENT_WIDTH-1:0] a_z,
	input  logic signed [COMPONENT_WIDTH-1:0] a_w,
	input  logic signed [COMPONENT_WIDTH-1:0] b_x,
	input  logic signed [COMPONENT_WIDTH-1:0] b_y,
	input  logic signed [COMPONENT_WIDTH-1:0] b_z,
	input  logic signed [COMPONENT_WIDTH-1:0] b_w,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [COMPONENT_WIDTH-1:0] r_x,
	output logic signed [COMPONENT_WIDTH-1:0] r_y,
	output logic signed [COMPONENT_WIDTH-1:0] r_z,
	output logic signed [COMPONENT_WIDTH-1:0] r_w,
	output qau_pkg::status_t                  status
);
	import qau_pkg::*;

	localparam int W  = COMPONENT_WIDTH;
	localparam int F  = FRACTION_BITS;
	localparam int PW = 2*W + 2;
	localparam int RW = W + 1;
	localparam int QW = F + 1;
	localparam int XW = QW + W;
	localparam int SW = 4*W + 8;

	localparam logic signed [PW-1:0] CMAX_P = $signed({{(W+3){1'b0}}, {(W-1){1'b1}}});
	localparam logic signed [PW-1:0] CMIN_P = $signed({{(W+3){1'b1}}, {(W-1){1'b0}}});
	localparam logic [PW-1:0]        HALF_U = {{(PW-1){1'b0}}, 1'b1} << (F-1);
	localparam logic [W-1:0]         MAX_W  = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]         MIN_W  = {1'b1, {(W-1){1'b0}}};
	localparam logic [XW-1:0]        LIM_P  = {{(QW+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic [XW-1:0]        LIM_N  = {{QW{1'b0}}, 1'b1, {(W-1){1'b0}}};

	function automatic logic signed [PW-1:0] sx(input logic signed [2*W-1:0] p);
		return $signed({{2{p[2*W-1]}}, p});
	endfunction

	// whole pipe advances together
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic signed [W-1:0] a_in [4];
	logic signed [W-1:0] b_in [4];
	assign a_in[0] = a_x;
	assign a_in[1] = a_y;
	assign a_in[2] = a_z;
	assign a_in[3] = a_w;
	assign b_in[0] = b_x;
	assign b_in[1] = b_y;
	assign b_in[2] = b_z;
	assign b_in[3] = b_w;

	// stage 1: all cross products, squares, sum and difference
	logic                  v_s1;
	op_t                   op_s1;
	logic signed [2*W-1:0] prod_s1 [4][4];
	logic signed [2*W-1:0] sq_s1   [4];
	logic signed [W:0]     sum_s1  [4];
	logic signed [W:0]     dif_s1  [4];
	logic signed [W-1:0]   a_s1    [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= operation;
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					prod_s1[i][j] <= a_in[i] * b_in[j];
				end
				sq_s1[i]  <= a_in[i] * a_in[i];
				sum_s1[i] <= $signed({a_in[i][W-1], a_in[i]}) + $signed({b_in[i][W-1], b_in[i]});
				dif_s1[i] <= $signed({a_in[i][W-1], a_in[i]}) - $signed({b_in[i][W-1], b_in[i]});
				a_s1[i]   <= a_in[i];
			end
		end
	end

	// stage 2: Hamilton sums, dot product, sum of squares (index 0 x, 1 y, 2 z, 3 w)
	logic                 v_s2;
	op_t                  op_s2;
	logic signed [PW-1:0] mul_s2 [4];
	logic signed [PW-1:0] dot_s2;
	logic [2*W:0]         sqs_s2;
	logic signed [W:0]    sum_s2 [4];
	logic signed [W:0]    dif_s2 [4];
	logic signed [W-1:0]  a_s2   [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2     <= op_s1;
			mul_s2[0] <= sx(prod_s1[3][0]) + sx(prod_s1[0][3]) + sx(prod_s1[1][2])
				- sx(prod_s1[2][1]);
			mul_s2[1] <= sx(prod_s1[3][1]) - sx(prod_s1[0][2]) + sx(prod_s1[1][3])
				+ sx(prod_s1[2][0]);
			mul_s2[2] <= sx(prod_s1[3][2]) + sx(prod_s1[0][1]) - sx(prod_s1[1][0])
				+ sx(prod_s1[2][3]);
			mul_s2[3] <= sx(prod_s1[3][3]) - sx(prod_s1[0][0]) - sx(prod_s1[1][1])
				- sx(prod_s1[2][2]);
			dot_s2    <= sx(prod_s1[0][0]) + sx(prod_s1[1][1]) + sx(prod_s1[2][2])
				+ sx(prod_s1[3][3]);
			sqs_s2    <= {1'b0, sq_s1[0]} + {1'b0, sq_s1[1]} + {1'b0, sq_s1[2]}
				+ {1'b0, sq_s1[3]};
			sum_s2    <= sum_s1;
			dif_s2    <= dif_s1;
			a_s2      <= a_s1;
		end
	end

	// stage 3: finish multiply, average and negate; prepare normalize
	logic signed [PW-1:0] mr_t  [4];
	logic signed [PW-1:0] mr_sh [4];
	logic [3:0][W-1:0]    mul_r;
	logic [3:0]           mul_sat;
	logic [3:0][W-1:0]    neg_r;
	logic [3:0]           amin;
	logic [3:0][W-1:0]    abs_r;
	logic [3:0][W-1:0]    avg_r;
	logic signed [W:0]    avg_v [4];
	logic                 flip;
	logic [3:0][W-1:0]    res_c;
	status_t              st_c;
	logic [3:0]           sgn_c;

	always_comb begin
		flip = dot_s2[PW-1];
		for (int i = 0; i < 4; i++) begin
			mr_t[i]  = mul_s2[i] + $signed(HALF_U);
			mr_sh[i] = mr_t[i] >>> F;
			if (mr_sh[i] > CMAX_P) begin
				mul_r[i]   = MAX_W;
				mul_sat[i] = 1'b1;
			end else if (mr_sh[i] < CMIN_P) begin
				mul_r[i]   = MIN_W;
				mul_sat[i] = 1'b1;
			end else begin
				mul_r[i]   = mr_sh[i][W-1:0];
				mul_sat[i] = 1'b0;
			end
			amin[i]  = (a_s2[i] == MIN_W);
			neg_r[i] = amin[i] ? MAX_W : (~a_s2[i] + 1'b1);
			abs_r[i] = a_s2[i][W-1] ? (~a_s2[i] + 1'b1) : a_s2[i];
			sgn_c[i] = a_s2[i][W-1];
			avg_v[i] = flip ? dif_s2[i] : sum_s2[i];
			avg_r[i] = avg_v[i][W:1];
		end
		case (op_s2)
			OP_MUL: begin
				res_c = mul_r;
				st_c  = (|mul_sat) ? ST_SAT : ST_OK;
			end
			OP_NORM: begin
				res_c = abs_r;
				st_c  = ST_OK;
			end
			OP_AVG: begin
				res_c = avg_r;
				st_c  = ST_OK;
			end
			OP_NEG: begin
				res_c = neg_r;
				st_c  = (|amin) ? ST_SAT : ST_OK;
			end
			default: begin
				res_c = mul_r;
				st_c  = ST_OK;
			end
		endcase
	end

	logic              v_s3;
	logic [3:0][W-1:0] res_s3;
	status_t           st_s3;
	logic              norm_s3;
	logic              zero_s3;
	logic [3:0]        sgn_s3;
	logic [2*RW-1:0]   rad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3  <= res_c;
			st_s3   <= st_c;
			norm_s3 <= (op_s2 == OP_NORM);
			zero_s3 <= (sqs_s2 == '0);
			sgn_s3  <= sgn_c;
			rad_s3  <= {1'b0, sqs_s2};
		end
	end

	// magnitude: floor square root of the sum of squares
	logic              sq_v;
	logic [RW-1:0]     sq_root;
	logic [SW-1:0]     sq_side;
	logic [3:0][W-1:0] sq_res;

	qau_isqrt_pipe #(
		.RW (RW),
		.SW (SW)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.radicand  (rad_s3),
		.in_side   ({res_s3, st_s3, norm_s3, zero_s3, sgn_s3}),
		.out_valid (sq_v),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	assign sq_res = sq_side[SW-1 -: 4*W];

	// stage 4: rounded numerators |c| << F + mag/2
	logic                     v_s4;
	logic [3:0][RW+QW-1:0]    num_s4;
	logic [RW-1:0]            mag_s4;
	logic [SW-1:0]            side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				num_s4[i] <= ({{(F+2){1'b0}}, sq_res[i]} << F)
					+ {{(QW+1){1'b0}}, sq_root[RW-1:1]};
			end
			mag_s4  <= sq_root;
			side_s4 <= sq_side;
		end
	end

	// per-component divide by the magnitude
	logic              dv_v;
	logic [3:0][QW-1:0] dv_q;
	logic [SW-1:0]     dv_side;
	logic [3:0][W-1:0] dv_res;
	status_t           dv_st;
	logic              dv_norm;
	logic              dv_zero;
	logic [3:0]        dv_sgn;

	qau_div_pipe #(
		.DW (RW),
		.QW (QW),
		.SW (SW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.divisor   (mag_s4),
		.numer     (num_s4),
		.in_side   (side_s4),
		.out_valid (dv_v),
		.quot      (dv_q),
		.out_side  (dv_side)
	);

	assign {dv_res, dv_st, dv_norm, dv_zero, dv_sgn} = dv_side;

	// final select: signed, saturated quotient for normalize (zero for a zero magnitude), else the earlier result
	logic [XW-1:0]     qx [4];
	logic [3:0][W-1:0] fin_res;
	logic [3:0]        nsat;
	status_t           fin_st;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			qx[i] = {{W{1'b0}}, dv_q[i]};
			if (dv_sgn[i]) begin
				nsat[i] = (qx[i] > LIM_N);
				fin_res[i] = nsat[i] ? MIN_W : (~qx[i][W-1:0] + 1'b1);
			end else begin
				nsat[i] = (qx[i] > LIM_P);
				fin_res[i] = nsat[i] ? MAX_W : qx[i][W-1:0];
			end
		end
		fin_st = (|nsat) ? ST_SAT : ST_OK;
		if (!dv_norm) begin
			fin_res = dv_res;
			fin_st  = dv_st;
		end else if (dv_zero) begin
			fin_res = '0;
			fin_st  = ST_ZERO;
		end
	end

	// output register
	logic [3:0][W-1:0] res_q;
	status_t           st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= fin_res;
			st_q  <= fin_st;
		end
	end

	assign r_x    = res_q[0];
	assign r_y    = res_q[1];
	assign r_z    = res_q[2];
	assign r_w    = res_q[3];
	assign status = st_q;

endmodule
